// ----- src/aatl_pkg.sv -----
// Package for the adaptive altitude thrust law: config types, reset values,
// register index codes and the 32-bit saturation helper.
// No dependencies.
`default_nettype none

package aatl_pkg;

  // Configuration register indexes, in port order
  typedef enum logic [2:0] {
    CfgGainA1     = 3'd0,
    CfgGainA2     = 3'd1,
    CfgGainA3     = 3'd2,
    CfgAdaptRate  = 3'd3,
    CfgGravity    = 3'd4,
    CfgMassInit   = 3'd5,
    CfgMassMin    = 3'd6,
    CfgMassMax    = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  // All registers are unsigned Q15.16 held in 31 bits
  typedef struct packed {
    logic [CfgDataW-1:0] gain_a1;
    logic [CfgDataW-1:0] gain_a2;
    logic [CfgDataW-1:0] gain_a3;
    logic [CfgDataW-1:0] adapt_rate;
    logic [CfgDataW-1:0] gravity;
    logic [CfgDataW-1:0] mass_initial;
    logic [CfgDataW-1:0] mass_min;
    logic [CfgDataW-1:0] mass_max;
  } cfg_t;

  // Reset values
  localparam logic [CfgDataW-1:0] GainA1Rst    = 31'd65536;
  localparam logic [CfgDataW-1:0] GainA2Rst    = 31'd65536;
  localparam logic [CfgDataW-1:0] GainA3Rst    = 31'd65536;
  localparam logic [CfgDataW-1:0] AdaptRateRst = 31'd66;
  localparam logic [CfgDataW-1:0] GravityRst   = 31'd64290816;
  localparam logic [CfgDataW-1:0] MassInitRst  = 31'd1900544;
  localparam logic [CfgDataW-1:0] MassMinRst   = 31'd1310720;
  localparam logic [CfgDataW-1:0] MassMaxRst   = 31'd2621440;

  // Thrust limit in whole units and as Q16.16
  localparam int unsigned ThrustLimit = 34220;
  localparam logic [31:0] ThrustMax   = 32'(ThrustLimit) << 16;

  // Shared multiplier: 33-bit signed operands, floor(a*b / 2^16) result
  localparam int unsigned MulOpW = 33;
  localparam int unsigned ProdW  = 48;

  // Clamp a signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v[48:31] == {18{v[31]}}) begin
      r = v[31:0];
    end else if (v[48]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/aatl_mul.sv -----
// Shared signed multiplier with registered Q16.16 floor result.
// Depends on aatl_pkg.
`default_nettype none

module aatl_mul
  import aatl_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic signed [MulOpW-1:0] op_a_i,
  input  wire logic signed [MulOpW-1:0] op_b_i,
  output logic signed [ProdW-1:0]       prod_o
);

  logic signed [2*MulOpW-1:0] full;

  // Operands stay within 32 signed bits, so the product fits in 64 bits;
  // dropping the low 16 bits of a two's complement value rounds to floor.
  assign full = op_a_i * op_b_i;

  always_ff @(posedge clk_i) begin
    prod_o <= full[63:16];
  end

endmodule

`default_nettype wire

// ----- src/aatl_cfg.sv -----
// Configuration register file of the altitude thrust law.
// Depends on aatl_pkg.
`default_nettype none

module aatl_cfg
  import aatl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_en_i,
  input  wire logic [CfgIdxW-1:0]  wr_idx_i,
  input  wire logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_idx_i))
        CfgGainA1:    cfg_d.gain_a1      = wr_data_i;
        CfgGainA2:    cfg_d.gain_a2      = wr_data_i;
        CfgGainA3:    cfg_d.gain_a3      = wr_data_i;
        CfgAdaptRate: cfg_d.adapt_rate   = wr_data_i;
        CfgGravity:   cfg_d.gravity      = wr_data_i;
        CfgMassInit:  cfg_d.mass_initial = wr_data_i;
        CfgMassMin:   cfg_d.mass_min     = wr_data_i;
        CfgMassMax:   cfg_d.mass_max     = wr_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_a1      <= GainA1Rst;
      cfg_q.gain_a2      <= GainA2Rst;
      cfg_q.gain_a3      <= GainA3Rst;
      cfg_q.adapt_rate   <= AdaptRateRst;
      cfg_q.gravity      <= GravityRst;
      cfg_q.mass_initial <= MassInitRst;
      cfg_q.mass_min     <= MassMinRst;
      cfg_q.mass_max     <= MassMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- src/adaptive_altitude_thrust_law_top.sv -----
// Top level of the adaptive altitude thrust law: stream ports, sequencer and
// datapath around one shared multiplier. Depends on aatl_pkg, aatl_mul, aatl_cfg.
// Timing: after an input item is accepted the sequencer steps from StX2d through StUpd,
//   and the result item is loaded into the output registers in StUpd. A new item is taken
//   only in idle; eight products go through the one registered multiplier. A stalled result
//   holds the update step. Reset: async, active low; control and config registers at reset values.
`default_nettype none

module adaptive_altitude_thrust_law_top
  import aatl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input items
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // measured_position, measured_velocity, ref_position, ref_velocity,
  // ref_acceleration (32 bits each, lowest first)
  input  wire logic [159:0]        s_axis_tdata,
  // restart_estimate
  input  wire logic                s_axis_tuser,
  // result items
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // thrust_out [31:0], mass_estimate_out [62:32], zero pad [63]
  output logic [63:0]              m_axis_tdata,
  // thrust_saturated
  output logic                     m_axis_tuser,
  // configuration writes
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // Sequencer states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StX2d   = 4'd1;
  localparam logic [3:0] StX2dd  = 4'd2;
  localparam logic [3:0] StE2    = 4'd3;
  localparam logic [3:0] StT1    = 4'd4;
  localparam logic [3:0] StT2    = 4'd5;
  localparam logic [3:0] StT3    = 4'd6;
  localparam logic [3:0] StT4    = 4'd7;
  localparam logic [3:0] StP     = 4'd8;
  localparam logic [3:0] StPe2   = 4'd9;
  localparam logic [3:0] StUpd   = 4'd10;

  logic [3:0] state_q, state_d;

  cfg_t cfg;

  logic signed [MulOpW-1:0] op_a, op_b;
  logic signed [ProdW-1:0]  prod;

  // Payload registers
  logic signed [31:0] vel_q, rvel_q, racc_q;
  logic signed [31:0] e1_q, de1_q, x2d_q, e2_q, x2dd_q, y_q, p_q;
  logic signed [49:0] acc_q;
  logic [31:0]        thr_q;
  logic               sat_q;
  logic [31:0]        out_thr_q;
  logic               out_sat_q;
  logic [30:0]        out_mass_q;

  // Control and state
  logic [30:0]        mass_q;
  logic               out_valid_q;

  logic               in_acc;
  logic               out_load;
  logic signed [48:0] prod_ext;
  logic signed [48:0] m_new;
  logic [30:0]        m_clamp;

  logic signed [31:0] pos_in, vel_in, rpos_in, rvel_in, racc_in;

  assign pos_in  = s_axis_tdata[31:0];
  assign vel_in  = s_axis_tdata[63:32];
  assign rpos_in = s_axis_tdata[95:64];
  assign rvel_in = s_axis_tdata[127:96];
  assign racc_in = s_axis_tdata[159:128];

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  aatl_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  aatl_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .prod_o (prod)
  );

  // Multiplier operand select per step; p*e2 stays applied while the update waits
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      StX2d: begin
        op_a = $signed({2'b00, cfg.gain_a2});
        op_b = {e1_q[31], e1_q};
      end
      StX2dd: begin
        op_a = $signed({2'b00, cfg.gain_a2});
        op_b = {de1_q[31], de1_q};
      end
      StE2: begin
        op_a = $signed({2'b00, cfg.gain_a1});
        op_b = {e1_q[31], e1_q};
      end
      StT1: begin
        op_a = $signed({2'b00, mass_q});
        op_b = {x2dd_q[31], x2dd_q};
      end
      StT2: begin
        op_a = $signed({2'b00, mass_q});
        op_b = $signed({2'b00, cfg.gravity});
      end
      StT3: begin
        op_a = $signed({2'b00, cfg.gain_a3});
        op_b = {e2_q[31], e2_q};
      end
      StT4: begin
        op_a = $signed({2'b00, cfg.adapt_rate});
        op_b = {y_q[31], y_q};
      end
      StPe2, StUpd: begin
        op_a = {p_q[31], p_q};
        op_b = {e2_q[31], e2_q};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_ext = {prod[ProdW-1], prod};

  // Mass update and clamp, lower limit tested first
  assign m_new = $signed({18'd0, mass_q}) + prod_ext;
  always_comb begin
    if (m_new < $signed({18'd0, cfg.mass_min})) begin
      m_clamp = cfg.mass_min;
    end else if (m_new > $signed({18'd0, cfg.mass_max})) begin
      m_clamp = cfg.mass_max;
    end else begin
      m_clamp = m_new[30:0];
    end
  end

  assign out_load = (state_q == StUpd) && (!out_valid_q || m_axis_tready);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc) state_d = StX2d;
      StX2d:   state_d = StX2dd;
      StX2dd:  state_d = StE2;
      StE2:    state_d = StT1;
      StT1:    state_d = StT2;
      StT2:    state_d = StT3;
      StT3:    state_d = StT4;
      StT4:    state_d = StP;
      StP:     state_d = StPe2;
      StPe2:   state_d = StUpd;
      StUpd:   if (out_load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control state: sequencer, mass estimate, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mass_q      <= MassInitRst;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && s_axis_tuser) begin
        mass_q <= cfg.mass_initial;
      end else if (out_load) begin
        mass_q <= m_clamp;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vel_q  <= vel_in;
      rvel_q <= rvel_in;
      racc_q <= racc_in;
      e1_q   <= sat32({{17{rpos_in[31]}}, rpos_in} - {{17{pos_in[31]}}, pos_in});
      de1_q  <= sat32({{17{rvel_in[31]}}, rvel_in} - {{17{vel_in[31]}}, vel_in});
    end
    unique case (state_q)
      StX2dd: begin
        x2d_q <= sat32(prod_ext + {{17{rvel_q[31]}}, rvel_q});
      end
      StE2: begin
        e2_q   <= sat32({{17{x2d_q[31]}}, x2d_q} - {{17{vel_q[31]}}, vel_q});
        x2dd_q <= sat32(prod_ext + {{17{racc_q[31]}}, racc_q});
      end
      StT1: begin
        acc_q <= {prod[ProdW-1], prod[ProdW-1], prod};
        y_q   <= sat32({{17{x2dd_q[31]}}, x2dd_q} + $signed({18'd0, cfg.gravity}));
      end
      StT2, StT3, StT4: begin
        acc_q <= acc_q + {prod[ProdW-1], prod[ProdW-1], prod};
      end
      StP: begin
        p_q <= sat32(prod_ext);
        if (acc_q[49]) begin
          thr_q <= '0;
          sat_q <= 1'b1;
        end else if (acc_q > $signed({18'd0, ThrustMax})) begin
          thr_q <= ThrustMax;
          sat_q <= 1'b1;
        end else begin
          thr_q <= acc_q[31:0];
          sat_q <= 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_thr_q  <= thr_q;
      out_sat_q  <= sat_q;
      out_mass_q <= m_clamp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_mass_q, out_thr_q};
  assign m_axis_tuser  = out_sat_q;

endmodule

`default_nettype wire

// ----- src/aatl_checker.sv -----
// Port-level checks for the adaptive altitude thrust law, bound to the top.
// Depends on aatl_pkg and adaptive_altitude_thrust_law_top.
`default_nettype none

module aatl_checker
  import aatl_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [63:0]         m_axis_tdata,
  input wire logic                m_axis_tuser
);

  // A pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // Thrust never exceeds the limit
  a_thr_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:0] <= ThrustMax)
    else $error("thrust above limit");

  // A saturated result sits on one of the two limits
  a_sat_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata[31:0] == 32'd0 || m_axis_tdata[31:0] == ThrustMax)
    else $error("saturation flag without limit value");

endmodule

bind adaptive_altitude_thrust_law_top aatl_checker u_aatl_checker (.*);

`default_nettype wire
